[rtl/timed_actuator_travel_controller_top_assert.svh]
// Assertion helpers for the travel controller.
`ifndef TIMED_ACTUATOR_TRAVEL_CONTROLLER_TOP_ASSERT_SVH
`define TIMED_ACTUATOR_TRAVEL_CONTROLLER_TOP_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define TATC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Same-cycle implication.
`define TATC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TATC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tatc_pkg.sv]
`default_nettype none

package tatc_pkg;

   localparam int TIME_W = 20;
   localparam int CMD_W  = 4;

   localparam logic [TIME_W-1:0] MAX_TRAVEL_RESET = TIME_W'(30000);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK      = 4'd0,
      CMD_UP_TIMED  = 4'd1,
      CMD_DN_TIMED  = 4'd2,
      CMD_UP_FULL   = 4'd3,
      CMD_DN_FULL   = 4'd4,
      CMD_AUTO      = 4'd5,
      CMD_MAN_UP    = 4'd6,
      CMD_MAN_DN    = 4'd7,
      CMD_STOP      = 4'd8,
      CMD_PRESET    = 4'd9
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [TIME_W-1:0] duration;
      logic [TIME_W-1:0] preset_value;
   } req_type;

   typedef struct packed {
      logic              drive_up;
      logic              drive_down;
      logic              moving;
      logic              latched_out;
      logic              auto_running;
      logic [TIME_W-1:0] position_out;
      logic [TIME_W-1:0] time_left;
   } rsp_type;

   // Controller state.
   typedef struct packed {
      logic [TIME_W-1:0] position;
      logic [TIME_W-1:0] countdown;
      logic              armed;
      logic              active;
      logic              latch;
      logic              cycle;
      logic              up;
      logic              down;
   } state_type;

endpackage

`default_nettype wire

[rtl/timed_actuator_travel_controller_top.sv]
`default_nettype none
// rsp_valid rises once a req transaction has passed the input register and then
// the result register. Throughput: one transaction per cycle while rsp_ready
// takes each result; one more is buffered while a result waits.
// csr writes are registered; csr_ready is always high.
// Reset (synchronous, active high): relays off, all flags and position cleared,
// max_travel back to 30000, both pipeline registers empty.

`include "timed_actuator_travel_controller_top_assert.svh"

module timed_actuator_travel_controller_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tatc_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tatc_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tatc_pkg::TIME_W-1:0]      csr_data
);

   localparam int TW = tatc_pkg::TIME_W;

   // Pipeline: input register -> next-state logic -> result register.
   logic                  in_valid_ff;
   tatc_pkg::req_type     in_data_ff;
   logic                  rsp_valid_ff;
   tatc_pkg::rsp_type     rsp_data_ff;
   tatc_pkg::rsp_type     rsp_data_in;

   // Controller state and travel range register.
   tatc_pkg::state_type   st_ff;
   tatc_pkg::state_type   st_in;
   logic [TW-1:0]         max_travel_ff;

   tatc_pkg::cmd_type     cmd;
   logic                  advance;

   // ---------------------------------------------------------------------
   // Movement helpers. The start helpers leave the state alone when a move is active.
   // ---------------------------------------------------------------------

   // Timed up run, clamped so the position never passes max_travel.
   function automatic tatc_pkg::state_type up_timed(tatc_pkg::state_type s,
                                                    logic [TW-1:0] ms,
                                                    logic [TW-1:0] m);
      tatc_pkg::state_type r;
      logic [TW:0]         sum;
      logic [TW-1:0]       run;
      r   = s;
      sum = {1'b0, s.position} + {1'b0, ms};
      if (s.position >= m) begin
         run = '0;
      end else if (sum > {1'b0, m}) begin
         run = m - s.position;
      end else begin
         run = ms;
      end
      if (!s.active) begin
         r.down      = 1'b0;
         r.up        = 1'b1;
         r.active    = 1'b1;
         r.position  = s.position + run;
         r.countdown = run;
         r.armed     = 1'b1;
      end
      return r;
   endfunction

   // Timed down run, clamped at closed.
   function automatic tatc_pkg::state_type dn_timed(tatc_pkg::state_type s,
                                                    logic [TW-1:0] ms);
      tatc_pkg::state_type r;
      logic [TW-1:0]       run;
      r   = s;
      run = (ms > s.position) ? s.position : ms;
      if (!s.active) begin
         r.up        = 1'b0;
         r.down      = 1'b1;
         r.active    = 1'b1;
         r.position  = s.position - run;
         r.countdown = run;
         r.armed     = 1'b1;
      end
      return r;
   endfunction

   // End of a movement: release latch, or step the auto cycle.
   function automatic tatc_pkg::state_type finish_run(tatc_pkg::state_type s,
                                                      logic [TW-1:0] m);
      tatc_pkg::state_type r;
      r        = s;
      r.up     = 1'b0;
      r.down   = 1'b0;
      r.active = 1'b0;
      if (r.cycle) begin
         if (r.position == '0) begin
            r.cycle = 1'b0;
            r.latch = 1'b0;
         end else if (r.position >= m) begin
            // top reached: full down (position is nonzero here)
            r.latch = 1'b1;
            r       = dn_timed(r, r.position);
         end
      end else begin
         r.latch = 1'b0;
      end
      return r;
   endfunction

   function automatic tatc_pkg::state_type dn_full(tatc_pkg::state_type s,
                                                   logic [TW-1:0] m);
      tatc_pkg::state_type r;
      r = s;
      if (!s.active) begin
         r.latch = 1'b1;
         if (r.position != '0) begin
            r = dn_timed(r, r.position);
         end else begin
            r = finish_run(r, m);
         end
      end
      return r;
   endfunction

   function automatic tatc_pkg::state_type up_full(tatc_pkg::state_type s,
                                                   logic [TW-1:0] m);
      tatc_pkg::state_type r;
      r = s;
      if (!s.active) begin
         r.latch = 1'b1;
         if (r.position < m) begin
            r = up_timed(r, m - r.position, m);
         end else begin
            r = finish_run(r, m);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Handshakes. The input register refills whenever it empties or moves on,
   // so one transaction can sit buffered while a result is stalled.
   // ---------------------------------------------------------------------
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Next state for the buffered transaction.
   // ---------------------------------------------------------------------
   always_comb begin
      cmd   = tatc_pkg::cmd_type'(in_data_ff.command);
      st_in = st_ff;
      case (cmd)
         tatc_pkg::CMD_TICK: begin
            // one-shot countdown; 0 or 1 expires
            if (st_ff.armed) begin
               if (st_ff.countdown <= TW'(1)) begin
                  st_in.countdown = '0;
                  st_in.armed     = 1'b0;
                  st_in           = finish_run(st_in, max_travel_ff);
               end else begin
                  st_in.countdown = st_ff.countdown - TW'(1);
               end
            end
         end
         tatc_pkg::CMD_UP_TIMED: begin
            st_in = up_timed(st_ff, in_data_ff.duration, max_travel_ff);
         end
         tatc_pkg::CMD_DN_TIMED: begin
            st_in = dn_timed(st_ff, in_data_ff.duration);
         end
         tatc_pkg::CMD_UP_FULL: begin
            st_in = up_full(st_ff, max_travel_ff);
         end
         tatc_pkg::CMD_DN_FULL: begin
            st_in = dn_full(st_ff, max_travel_ff);
         end
         tatc_pkg::CMD_AUTO: begin
            if (!st_ff.active) begin
               st_in.latch = 1'b1;
               st_in.cycle = 1'b1;
               st_in       = up_full(st_in, max_travel_ff);
            end
         end
         tatc_pkg::CMD_MAN_UP: begin
            if (!st_ff.active) begin
               st_in.up     = 1'b1;
               st_in.down   = 1'b0;
               st_in.active = 1'b1;
               st_in.latch  = 1'b0;
            end
         end
         tatc_pkg::CMD_MAN_DN: begin
            if (!st_ff.active) begin
               st_in.up     = 1'b0;
               st_in.down   = 1'b1;
               st_in.active = 1'b1;
               st_in.latch  = 1'b0;
            end
         end
         tatc_pkg::CMD_STOP: begin
            st_in.armed     = 1'b0;
            st_in.countdown = '0;
            st_in.up        = 1'b0;
            st_in.down      = 1'b0;
            st_in.active    = 1'b0;
            st_in.latch     = 1'b0;
            st_in.cycle     = 1'b0;
         end
         tatc_pkg::CMD_PRESET: begin
            st_in.position = (in_data_ff.preset_value > max_travel_ff) ?
                             max_travel_ff : in_data_ff.preset_value;
         end
         default: begin
            st_in = st_ff;   // unused codes
         end
      endcase

      rsp_data_in.drive_up     = st_in.up;
      rsp_data_in.drive_down   = st_in.down;
      rsp_data_in.moving       = st_in.active;
      rsp_data_in.latched_out  = st_in.latch;
      rsp_data_in.auto_running = st_in.cycle;
      rsp_data_in.position_out = st_in.position;
      rsp_data_in.time_left    = st_in.armed ? st_in.countdown : '0;
   end

   // ---------------------------------------------------------------------
   // Control registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         st_ff         <= '0;
         max_travel_ff <= tatc_pkg::MAX_TRAVEL_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            max_travel_ff <= csr_data;
         end
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------
   `TATC_ASSERT_ALWAYS(a_relays_exclusive, clock, reset,
      !(st_ff.up && st_ff.down), "both relays energized")
   `TATC_ASSERT_IMPLY(a_drive_needs_move, clock, reset,
      st_ff.up || st_ff.down, st_ff.active, "relay driven with no active move")
   `TATC_ASSERT_IMPLY(a_timer_needs_move, clock, reset,
      st_ff.armed, st_ff.active, "timer armed with no active move")
   `TATC_ASSERT_NEXT(a_buffer_held, clock, reset,
      in_valid_ff && !advance, in_valid_ff, "buffered transaction dropped")

endmodule

`default_nettype wire

[tb/tb_timed_actuator_travel_controller_top.sv]
module tb_timed_actuator_travel_controller_top;
   import tatc_pkg::*;

   // Watchdog ceiling, far above the slowest legal run (every item stretched
   // by the largest sender gap and receiver stall, plus drains around writes).
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;
   // First command code the controller does not decode.
   localparam logic [CMD_W-1:0] FIRST_SPARE_CODE = CMD_W'(CMD_PRESET + 1);
   // Ticks allowed per random move before it is cut short with a stop.
   localparam int MAX_TICKS_PER_MOVE = 48;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [TIME_W-1:0] csr_data = '0;

   // Expected status words, oldest first, one per accepted request.
   rsp_type     expected_status_q[$];
   int          mismatch_count = 0;
   int          sent_count = 0;
   int unsigned cycle_count = 0;
   // When set, both sides run without idle cycles.
   bit          quiet_mode = 1'b0;

   // Shadow copy of the controller state and its travel register.
   logic [TIME_W-1:0] est_travel = MAX_TRAVEL_RESET;
   logic [TIME_W-1:0] est_position = '0;
   logic [TIME_W-1:0] est_countdown = '0;
   logic              est_armed = 1'b0;
   logic              est_moving = 1'b0;
   logic              est_latched = 1'b0;
   logic              est_cycling = 1'b0;
   logic              est_up = 1'b0;
   logic              est_down = 1'b0;

   timed_actuator_travel_controller_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Travel predictor
   // ---------------------------------------------------------------

   function automatic void halt_model_drive();
      est_up = 1'b0;
      est_down = 1'b0;
      est_moving = 1'b0;
   endfunction

   // Timed up run, clamped so the estimate never passes the travel limit.
   function automatic void start_timed_up(input logic [TIME_W-1:0] run_ms);
      logic [TIME_W:0] reach;
      if (est_moving) return;
      reach = {1'b0, est_position} + {1'b0, run_ms};
      if (est_position >= est_travel) begin
         run_ms = '0;
      end else if (reach > {1'b0, est_travel}) begin
         run_ms = est_travel - est_position;
      end
      est_down = 1'b0;
      est_up = 1'b1;
      est_moving = 1'b1;
      est_position = est_position + run_ms;
      est_countdown = run_ms;
      est_armed = 1'b1;
   endfunction

   // Timed down run, clamped at the closed end.
   function automatic void start_timed_down(input logic [TIME_W-1:0] run_ms);
      if (est_moving) return;
      if (run_ms > est_position) begin
         run_ms = est_position;
      end
      est_up = 1'b0;
      est_down = 1'b1;
      est_moving = 1'b1;
      est_position = est_position - run_ms;
      est_countdown = run_ms;
      est_armed = 1'b1;
   endfunction

   // End of a run: drop the relays, then release the latch or step the auto cycle.
   function automatic void finish_model_move();
      halt_model_drive();
      if (est_cycling) begin
         if (est_position == '0) begin
            est_cycling = 1'b0;
            est_latched = 1'b0;
         end else if (est_position >= est_travel) begin
            start_full_down();
         end
      end else begin
         est_latched = 1'b0;
      end
   endfunction

   function automatic void start_full_down();
      if (est_moving) return;
      est_latched = 1'b1;
      if (est_position != '0) begin
         start_timed_down(est_position);
      end else begin
         finish_model_move();
      end
   endfunction

   function automatic void start_full_up();
      if (est_moving) return;
      est_latched = 1'b1;
      if (est_position < est_travel) begin
         start_timed_up(est_travel - est_position);
      end else begin
         finish_model_move();
      end
   endfunction

   function automatic void start_manual(input logic go_up);
      if (est_moving) return;
      est_up = go_up;
      est_down = ~go_up;
      est_moving = 1'b1;
      est_latched = 1'b0;
   endfunction

   // Applies one request to the shadow state and returns the status it produces.
   function automatic rsp_type predict_status(input req_type item);
      rsp_type status;
      case (item.command)
         CMD_TICK: begin
            if (est_armed) begin
               if (est_countdown <= 1) begin
                  est_countdown = '0;
                  est_armed = 1'b0;
                  finish_model_move();
               end else begin
                  est_countdown = est_countdown - 1'b1;
               end
            end
         end
         CMD_UP_TIMED: start_timed_up(item.duration);
         CMD_DN_TIMED: start_timed_down(item.duration);
         CMD_UP_FULL:  start_full_up();
         CMD_DN_FULL:  start_full_down();
         CMD_AUTO: begin
            if (!est_moving) begin
               est_latched = 1'b1;
               est_cycling = 1'b1;
               start_full_up();
            end
         end
         CMD_MAN_UP: start_manual(1'b1);
         CMD_MAN_DN: start_manual(1'b0);
         CMD_STOP: begin
            est_armed = 1'b0;
            est_countdown = '0;
            halt_model_drive();
            est_latched = 1'b0;
            est_cycling = 1'b0;
         end
         CMD_PRESET: begin
            est_position = (item.preset_value > est_travel) ? est_travel
                                                            : item.preset_value;
         end
         default: ;
      endcase
      status.drive_up = est_up;
      status.drive_down = est_down;
      status.moving = est_moving;
      status.latched_out = est_latched;
      status.auto_running = est_cycling;
      status.position_out = est_position;
      status.time_left = est_armed ? est_countdown : '0;
      return status;
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------

   // Sends one request transaction after a random idle gap. Valid is left high
   // on return so back-to-back requests never lower and raise it in one step.
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [TIME_W-1:0] run_ms,
                               input logic [TIME_W-1:0] preset_ms);
      int      gap;
      req_type item;
      gap = quiet_mode ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.command = cmd;
      item.duration = run_ms;
      item.preset_value = preset_ms;
      req_payload <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_status_q.push_back(predict_status(item));
      sent_count++;
   endtask

   // Register write, only with the controller drained of all work.
   task automatic write_max_travel(input logic [TIME_W-1:0] travel_ms);
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      // Let the two-stage pipeline settle before touching the register.
      repeat (4) @(posedge clock);
      csr_data <= travel_ms;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      est_travel = travel_ms;
   endtask

   // Run lengths: mostly short, with zero, all-ones, wide random values and
   // values around the remaining travel mixed in.
   function automatic logic [TIME_W-1:0] pick_run_time();
      case ($urandom_range(0, 9))
         6:       return '0;
         7:       return TIME_ALL_ONES;
         8:       return TIME_W'($urandom);
         9:       return est_travel - est_position + TIME_W'($urandom_range(0, 2)) - 1'b1;
         default: return TIME_W'($urandom_range(0, 12));
      endcase
   endfunction

   // Preset targets: near the top, near closed, anywhere, or all-ones.
   function automatic logic [TIME_W-1:0] pick_position();
      logic [TIME_W-1:0] back_off;
      back_off = TIME_W'($urandom_range(0, 4));
      case ($urandom_range(0, 3))
         0:       return (est_travel > back_off) ? est_travel - back_off : '0;
         1:       return back_off;
         2:       return TIME_W'($urandom);
         default: return TIME_ALL_ONES;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Out of reset: preset saturates at the reset travel limit, an up run at the
   // top lasts a single tick, and spare codes leave everything alone.
   task automatic test_reset_travel_limit();
      send_request(CMD_PRESET, '0, TIME_ALL_ONES);
      send_request(CMD_UP_TIMED, TIME_W'(7), '0);
      send_request(CMD_TICK, '0, '0);
      send_request(FIRST_SPARE_CODE, TIME_ALL_ONES, TIME_ALL_ONES);
   endtask

   // Clamped up and down runs, busy rejection, countdown expiry, stop mid-run.
   task automatic test_timed_runs();
      write_max_travel(TIME_W'(8));
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_PRESET, '0, TIME_W'(6));
      send_request(CMD_UP_TIMED, TIME_ALL_ONES, '0);
      send_request(CMD_DN_TIMED, TIME_W'(1), '0);
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_DN_TIMED, TIME_ALL_ONES, '0);
      send_request(CMD_STOP, '0, '0);
   endtask

   // Full down with no room, an auto cycle parked mid-travel by a preset, a
   // manual move that keeps the cycle flag, then a complete up-then-down cycle.
   task automatic test_full_and_auto_cycle();
      write_max_travel(TIME_W'(2));
      send_request(CMD_DN_FULL, '0, '0);
      send_request(CMD_AUTO, '0, '0);
      send_request(CMD_PRESET, '0, TIME_W'(1));
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_MAN_DN, '0, '0);
      send_request(CMD_STOP, '0, '0);
      send_request(CMD_AUTO, '0, '0);
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_TICK, '0, '0);
   endtask

   // With no travel at all the auto cycle and full moves end immediately.
   task automatic test_zero_travel_range();
      write_max_travel('0);
      send_request(CMD_AUTO, '0, '0);
      send_request(CMD_UP_FULL, '0, '0);
      send_request(CMD_MAN_UP, '0, '0);
      send_request(CMD_STOP, '0, '0);
   endtask

   // Random move sequences under one travel setting: optional preset, a move,
   // ticks until it ends or is cut short, with stray commands mixed in.
   task automatic test_random_traffic(input logic [TIME_W-1:0] travel_ms,
                                      input int budget);
      int               last_item;
      int               tick_cap;
      logic [CMD_W-1:0] move;
      write_max_travel(travel_ms);
      last_item = sent_count + budget;
      while (sent_count < last_item) begin
         quiet_mode = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) == 0) begin
            send_request(CMD_PRESET, TIME_W'($urandom), pick_position());
         end
         move = CMD_W'($urandom_range(CMD_UP_TIMED, CMD_MAN_DN));
         send_request(move, pick_run_time(), pick_position());
         // Manual moves never end on their own, so keep their runs short.
         tick_cap = (move == CMD_MAN_UP || move == CMD_MAN_DN)
                    ? $urandom_range(0, 6) : $urandom_range(0, MAX_TICKS_PER_MOVE);
         for (int k = 0; k < tick_cap && est_moving; k++) begin
            if ($urandom_range(0, 19) == 0) begin
               send_request(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)),
                            pick_run_time(), TIME_W'($urandom));
            end else begin
               send_request(CMD_TICK, TIME_W'($urandom), TIME_W'($urandom));
            end
         end
         if (est_moving || $urandom_range(0, 9) == 0) begin
            send_request(CMD_STOP, TIME_W'($urandom), TIME_W'($urandom));
         end
      end
      quiet_mode = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Result side: random stalls on rsp_ready, one check per transaction
   // ---------------------------------------------------------------

   task automatic check_field(input string label, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   initial begin : status_checker
      int      stall;
      rsp_type want;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = quiet_mode ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (expected_status_q.size() == 0) begin
            $display("%0t: status with no request pending, expected none, actual %p",
                     $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_status_q.pop_front();
            check_field("drive_up", TIME_W'(want.drive_up),
                        TIME_W'(rsp_payload.drive_up));
            check_field("drive_down", TIME_W'(want.drive_down),
                        TIME_W'(rsp_payload.drive_down));
            check_field("moving", TIME_W'(want.moving), TIME_W'(rsp_payload.moving));
            check_field("latched_out", TIME_W'(want.latched_out),
                        TIME_W'(rsp_payload.latched_out));
            check_field("auto_running", TIME_W'(want.auto_running),
                        TIME_W'(rsp_payload.auto_running));
            check_field("position_out", want.position_out, rsp_payload.position_out);
            check_field("time_left", want.time_left, rsp_payload.time_left);
         end
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_travel_limit();
      test_timed_runs();
      test_full_and_auto_cycle();
      test_zero_travel_range();

      // Travel settings span the extremes, small random limits and the reset value.
      test_random_traffic(TIME_W'(1), 300);
      test_random_traffic(TIME_ALL_ONES, 300);
      test_random_traffic(TIME_W'($urandom_range(3, 60)), 350);
      test_random_traffic('0, 150);
      test_random_traffic(TIME_W'($urandom), 300);
      test_random_traffic(MAX_TRAVEL_RESET, 250);
      test_random_traffic(TIME_W'($urandom_range(3, 60)), 300);

      // Drain outstanding status, then allow for the pipeline depth.
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
